// ===== rtl/dcm_pkg.sv =====
// ----------------------------------------------------------------------------
// dcm_pkg
// Shared types and constants of the disc clear mask engine: stream field
// layout, operation codes, register indexes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dcm_pkg;

  // input item field widths
  localparam int FUNC_W   = 2;
  localparam int IDX_W    = 16;
  localparam int WORD_W   = 32;
  localparam int CTR_W    = 18;
  localparam int RAD_IN_W = 7;

  // centre fixed point
  localparam int FRAC_W = 16;

  // in_tdata layout, lowest field first
  localparam int IDX_LSB      = 0;
  localparam int WORD_LSB     = IDX_LSB + IDX_W;
  localparam int CX_LSB       = WORD_LSB + WORD_W;
  localparam int CY_LSB       = CX_LSB + CTR_W;
  localparam int RAD_LSB      = CY_LSB + CTR_W;
  localparam int IN_FIELDS_W  = RAD_LSB + RAD_IN_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_TUSER_W   = FUNC_W;

  // result layout
  localparam int OUT_TDATA_W  = 32;
  localparam int OUT_TUSER_W  = FUNC_W;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASK_WIDTH  = 1'b0,
    CFG_MASK_HEIGHT = 1'b1
  } cfg_reg_t;

  // operation codes carried in tuser
  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD  = 2'd0,
    FN_READ  = 2'd1,
    FN_CARVE = 2'd2
  } func_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SETUP,
    OP_ROW_A,
    OP_ROW_B,
    OP_SPAN,
    OP_SPAN2,
    OP_CLEAR,
    OP_NEXT,
    OP_RESP
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ROW_A,
    ST_ROW_B,
    ST_SQRT,
    ST_SPAN,
    ST_SPAN2,
    ST_CLEAR,
    ST_NEXT,
    ST_RESP
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              row_ok;
    logic              sqrt_done;
    logic              span_empty;
    logic              col_last;
    logic              m_last;
    logic              slot_free;
  } dp_status_t;

endpackage

// ===== rtl/dcm_ram.sv =====
// ----------------------------------------------------------------------------
// dcm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dcm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/dcm_isqrt.sv =====
// ----------------------------------------------------------------------------
// dcm_isqrt
// Bit-serial integer square root: one root bit per cycle, exact floor.
// ----------------------------------------------------------------------------
module dcm_isqrt #(
  parameter int RB = 15
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*RB-1:0] radicand,
  output logic [RB-1:0]   root,
  output logic            done
);

  localparam int REMW = RB + 3;
  localparam int CNTW = $clog2(RB + 1);

  logic [2*RB-1:0] n_r;
  logic [REMW-1:0] rem_r;
  logic [RB-1:0]   root_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;

  logic [REMW-1:0] rem_sh;
  logic [REMW-1:0] trial;
  logic            take;

  // bring down the next two radicand bits and try root*4+1
  assign rem_sh = {rem_r[REMW-3:0], n_r[2*RB-1 -: 2]};
  assign trial  = REMW'({root_r, 2'b01});
  assign take   = (rem_sh >= trial);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNTW'(RB);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      n_r <= {n_r[2*RB-3:0], 2'b00};
      if (take) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[RB-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[RB-2:0], 1'b0};
      end
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

// ===== rtl/dcm_datapath.sv =====
// ----------------------------------------------------------------------------
// dcm_datapath
// Mask memory, size registers, disc geometry registers, span arithmetic,
// square root unit and the result register.
// ----------------------------------------------------------------------------
module dcm_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 100,
  parameter int PIXEL_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [dcm_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [dcm_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [dcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dcm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [dcm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [dcm_pkg::OUT_TUSER_W-1:0]    out_tuser,
  input  dcm_pkg::dp_cmd_t                   cmd,
  output dcm_pkg::dp_status_t                status
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RADW  = $clog2(MAX_RADIUS + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CXW   = dcm_pkg::CTR_W + WW + 1;
  localparam int CYW   = dcm_pkg::CTR_W + HW + 1;
  localparam int RB    = RADW + 8;
  localparam int HWW   = RB + 8;
  localparam int SPW   = ((CXW > HWW) ? CXW : HWW + 1) + 1;
  localparam int W_RST = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;
  localparam int H_RST = (256 > MAX_HEIGHT) ? MAX_HEIGHT : 256;
  localparam logic signed [SPW-1:0] ONE_S = SPW'(1);

  // input fields
  logic [dcm_pkg::FUNC_W-1:0]          in_func;
  logic [dcm_pkg::IDX_W-1:0]           in_idx;
  logic [dcm_pkg::WORD_W-1:0]          in_word;
  logic signed [dcm_pkg::CTR_W-1:0]    in_cx;
  logic signed [dcm_pkg::CTR_W-1:0]    in_cy;
  logic [dcm_pkg::RAD_IN_W-1:0]        in_rad;
  logic                                in_idx_ok;
  logic [RADW-1:0]                     rad_sat;
  logic                                accept;

  assign in_func = in_tuser[dcm_pkg::FUNC_W-1:0];
  assign in_idx  = in_tdata[dcm_pkg::IDX_LSB +: dcm_pkg::IDX_W];
  assign in_word = in_tdata[dcm_pkg::WORD_LSB +: dcm_pkg::WORD_W];
  assign in_cx   = $signed(in_tdata[dcm_pkg::CX_LSB +: dcm_pkg::CTR_W]);
  assign in_cy   = $signed(in_tdata[dcm_pkg::CY_LSB +: dcm_pkg::CTR_W]);
  assign in_rad  = in_tdata[dcm_pkg::RAD_LSB +: dcm_pkg::RAD_IN_W];
  assign accept  = (cmd.op == dcm_pkg::OP_ACCEPT);

  assign in_idx_ok = (32'(in_idx) < DEPTH);
  assign rad_sat   = (32'(in_rad) > MAX_RADIUS) ? RADW'(MAX_RADIUS) : RADW'(in_rad);

  // size registers, kept already clamped to the supported range
  logic [WW-1:0] w_eff_r;
  logic [HW-1:0] h_eff_r;
  logic [WW-1:0] w_clamp;
  logic [HW-1:0] h_clamp;

  assign w_clamp = (cfg_data == '0) ? WW'(1) :
                   ((32'(cfg_data) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_data));
  assign h_clamp = (cfg_data == '0) ? HW'(1) :
                   ((32'(cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= WW'(W_RST);
      h_eff_r <= HW'(H_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dcm_pkg::CFG_MASK_WIDTH:  w_eff_r <= w_clamp;
        dcm_pkg::CFG_MASK_HEIGHT: h_eff_r <= h_clamp;
        default: ;
      endcase
    end
  end

  // item registers
  logic [dcm_pkg::FUNC_W-1:0]       func_r;
  logic                             rd_ok_r;
  logic signed [dcm_pkg::CTR_W-1:0] ux_r;
  logic signed [dcm_pkg::CTR_W-1:0] uy_r;
  logic [RADW-1:0]                  r_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_func;
      rd_ok_r <= in_idx_ok;
      ux_r    <= in_cx;
      uy_r    <= in_cy;
      r_r     <= rad_sat;
    end
  end

  // geometry registers
  logic signed [CXW-1:0]  cx_r;
  logic signed [CYW-1:0]  cy_r;
  logic [2*RADW-1:0]      rsq_r;
  logic signed [RADW:0]   m_r;
  logic [2*RADW-1:0]      msq_r;
  logic signed [CYW-1:0]  row_r;
  logic signed [SPW-1:0]  first_r;
  logic signed [SPW-1:0]  last_r;
  logic [AW-1:0]          rowbase_r;
  logic [WW-1:0]          col_r;
  logic [WW-1:0]          last_col_r;
  logic [AW-1:0]          addr_r;

  logic signed [CXW-1:0]  cx_prod;
  logic signed [CYW-1:0]  cy_prod;
  logic [2*RADW-1:0]      rsq_prod;
  logic [RADW-1:0]        m_abs;
  logic [2*RADW-1:0]      msq_prod;
  logic [2*RADW-1:0]      rad_diff;
  logic [RB-1:0]          root;
  logic                   sqrt_done;
  logic                   sqrt_start;
  logic [HWW-1:0]         hw_fix;
  logic signed [SPW-1:0]  lo_sum;
  logic signed [SPW-1:0]  hi_sum;
  logic signed [SPW-1:0]  first_q;
  logic signed [SPW-1:0]  last_q;
  logic signed [SPW-1:0]  wmax_s;
  logic [WW-1:0]          w_m1;
  logic [WW+HW-1:0]       rb_prod;
  logic                   row_ok;

  // centre scaling and radius square
  assign cx_prod  = ux_r * $signed({1'b0, w_eff_r});
  assign cy_prod  = uy_r * $signed({1'b0, h_eff_r});
  assign rsq_prod = r_r * r_r;

  // row offset square and radicand
  assign m_abs    = m_r[RADW] ? RADW'(-m_r) : RADW'(m_r);
  assign msq_prod = m_abs * m_abs;
  assign rad_diff = rsq_r - msq_r;

  assign row_ok = !row_r[CYW-1] && (row_r < $signed(CYW'(h_eff_r)));

  assign sqrt_start = (cmd.op == dcm_pkg::OP_ROW_B) && row_ok;

  dcm_isqrt #(
    .RB (RB)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({rad_diff, 16'h0000}),
    .root     (root),
    .done     (sqrt_done)
  );

  // span bounds: floor(cx - hw) and floor(cx + hw - 2^-16), clamped to the mask
  assign hw_fix  = {root, 8'h00};
  assign lo_sum  = SPW'(cx_r) - $signed(SPW'(hw_fix));
  assign hi_sum  = SPW'(cx_r) + $signed(SPW'(hw_fix)) - ONE_S;
  assign first_q = lo_sum >>> dcm_pkg::FRAC_W;
  assign last_q  = hi_sum >>> dcm_pkg::FRAC_W;
  assign w_m1    = w_eff_r - WW'(1);
  assign wmax_s  = $signed(SPW'(w_m1));
  assign rb_prod = w_eff_r * row_r[HW-1:0];

  always_ff @(posedge clk) begin
    case (cmd.op)
      dcm_pkg::OP_SETUP: begin
        cx_r  <= cx_prod;
        cy_r  <= cy_prod;
        rsq_r <= rsq_prod;
        m_r   <= -$signed({1'b0, r_r});
      end
      dcm_pkg::OP_ROW_A: begin
        msq_r <= msq_prod;
        row_r <= (cy_r >>> dcm_pkg::FRAC_W) + CYW'(m_r);
      end
      dcm_pkg::OP_SPAN: begin
        first_r   <= first_q[SPW-1] ? '0 : first_q;
        last_r    <= (last_q > wmax_s) ? wmax_s : last_q;
        rowbase_r <= AW'(rb_prod);
      end
      dcm_pkg::OP_SPAN2: begin
        col_r      <= first_r[WW-1:0];
        last_col_r <= last_r[WW-1:0];
        addr_r     <= rowbase_r + AW'(first_r[WW-1:0]);
      end
      dcm_pkg::OP_CLEAR: begin
        col_r  <= col_r + WW'(1);
        addr_r <= addr_r + AW'(1);
      end
      dcm_pkg::OP_NEXT: begin
        m_r <= m_r + (RADW+1)'(1);
      end
      default: ;
    endcase
  end

  // mask memory: loads and span clearing share the write port
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [PIXEL_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [PIXEL_BITS-1:0] ram_rdata;
  logic                  clearing;

  assign clearing  = (cmd.op == dcm_pkg::OP_CLEAR);
  assign ram_we    = clearing || (accept && (in_func == dcm_pkg::FN_LOAD) && in_idx_ok);
  assign ram_waddr = clearing ? addr_r : AW'(in_idx);
  assign ram_wdata = clearing ? '0 : PIXEL_BITS'(in_word);
  assign ram_re    = accept && (in_func == dcm_pkg::FN_READ);

  dcm_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_mask_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (AW'(in_idx)),
    .rdata (ram_rdata)
  );

  // result register
  logic                            out_valid_r;
  logic [dcm_pkg::OUT_TDATA_W-1:0] out_word_r;
  logic [dcm_pkg::OUT_TUSER_W-1:0] out_kind_r;
  logic                            slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == dcm_pkg::OP_RESP) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == dcm_pkg::OP_RESP) begin
      out_kind_r <= func_r;
      out_word_r <= ((func_r == dcm_pkg::FN_READ) && rd_ok_r) ?
                    dcm_pkg::OUT_TDATA_W'(ram_rdata) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tuser  = out_kind_r;

  // status to the controller
  always_comb begin
    status.func       = in_func;
    status.row_ok     = row_ok;
    status.sqrt_done  = sqrt_done;
    status.span_empty = (first_r > last_r);
    status.col_last   = (col_r == last_col_r);
    status.m_last     = (m_r == $signed({1'b0, r_r}));
    status.slot_free  = slot_free;
  end

endmodule

// ===== rtl/dcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcm_ctrl
// Controller: accepts one item at a time, sequences the row walk of a carve
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module dcm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output dcm_pkg::dp_cmd_t    cmd,
  input  dcm_pkg::dp_status_t status
);

  dcm_pkg::ctrl_state_t state_r;
  dcm_pkg::ctrl_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dcm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = rst_n && (state_r == dcm_pkg::ST_IDLE);

  // next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = dcm_pkg::OP_NONE;
    case (state_r)
      dcm_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.op = dcm_pkg::OP_ACCEPT;
          if (status.func == dcm_pkg::FN_CARVE) begin
            state_nxt = dcm_pkg::ST_SETUP;
          end else begin
            state_nxt = dcm_pkg::ST_RESP;
          end
        end
      end
      dcm_pkg::ST_SETUP: begin
        cmd.op    = dcm_pkg::OP_SETUP;
        state_nxt = dcm_pkg::ST_ROW_A;
      end
      dcm_pkg::ST_ROW_A: begin
        cmd.op    = dcm_pkg::OP_ROW_A;
        state_nxt = dcm_pkg::ST_ROW_B;
      end
      dcm_pkg::ST_ROW_B: begin
        cmd.op    = dcm_pkg::OP_ROW_B;
        state_nxt = status.row_ok ? dcm_pkg::ST_SQRT : dcm_pkg::ST_NEXT;
      end
      dcm_pkg::ST_SQRT: begin
        if (status.sqrt_done) begin
          state_nxt = dcm_pkg::ST_SPAN;
        end
      end
      dcm_pkg::ST_SPAN: begin
        cmd.op    = dcm_pkg::OP_SPAN;
        state_nxt = dcm_pkg::ST_SPAN2;
      end
      dcm_pkg::ST_SPAN2: begin
        cmd.op    = dcm_pkg::OP_SPAN2;
        state_nxt = status.span_empty ? dcm_pkg::ST_NEXT : dcm_pkg::ST_CLEAR;
      end
      dcm_pkg::ST_CLEAR: begin
        cmd.op = dcm_pkg::OP_CLEAR;
        if (status.col_last) begin
          state_nxt = dcm_pkg::ST_NEXT;
        end
      end
      dcm_pkg::ST_NEXT: begin
        cmd.op    = dcm_pkg::OP_NEXT;
        state_nxt = status.m_last ? dcm_pkg::ST_RESP : dcm_pkg::ST_ROW_A;
      end
      dcm_pkg::ST_RESP: begin
        if (status.slot_free) begin
          cmd.op    = dcm_pkg::OP_RESP;
          state_nxt = dcm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dcm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/disc_clear_mask_engine.sv =====
// ----------------------------------------------------------------------------
// disc_clear_mask_engine
// Pixel mask memory with word load, word read and filled disc clearing.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one operation per transfer: load a word, read a word or
//   carve a disc. out_* returns one result per operation, in order: the
//   word on a read, zero otherwise, with the operation code echoed in tuser.
//   cfg_* writes the mask width and height in use; write it only while idle.
// Sequencing:
//   load and read go via the respond step to the result register (the
//   read uses the registered RAM port); no new item is taken before
//   that. A carve has a setup step and, for each of its 2r+1 rows, two
//   row steps, then for a row inside the mask an RB-bit square root
//   (RB = radius bits + 8), two span steps and one clear step per
//   cleared pixel on the single RAM write port, then a next-row step.
// Reset:
//   synchronous, active low; sizes return to 256 by 256 (clamped to the
//   maximums). Mask contents are not cleared and are undefined until written.
// Stalls:
//   a result waits in the output register while out_tready is low; the
//   block takes one more item and works it through, then holds that item's
//   result and the input until the register frees.
// ----------------------------------------------------------------------------
module disc_clear_mask_engine #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 100,
  parameter int PIXEL_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [15:0] pixel_index, [47:16] pixel_word, [65:48] centre_x,
  // [83:66] centre_y, [90:84] disc_radius, [95:91] zero
  input  logic [dcm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] func
  input  logic [dcm_pkg::IN_TUSER_W-1:0]  in_tuser,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] read_word
  output logic [dcm_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [1:0] reply_kind
  output logic [dcm_pkg::OUT_TUSER_W-1:0] out_tuser,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dcm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  dcm_pkg::dp_cmd_t    cmd;
  dcm_pkg::dp_status_t status;

  assign cfg_ready = rst_n;

  // controller
  dcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .status    (status)
  );

  // datapath
  dcm_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .status     (status)
  );

  // one item at a time: an input transfer leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // clearing only runs over a non-empty span
  a_clear_span: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == dcm_pkg::OP_CLEAR |-> !status.span_empty)
    else $error("clear step on an empty span");

  // a result appears only when the controller hands one over
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.op == dcm_pkg::OP_RESP))
    else $error("result valid without a handover");

  // a new square root never reports the previous row's root as done
  a_sqrt_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == dcm_pkg::OP_ROW_B && status.row_ok |=> !status.sqrt_done)
    else $error("square root done flag not cleared on start");

endmodule
